### hdl/rshs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rshs_pkg;

  localparam int SAMPLE_W  = 64;
  localparam int SCOUNT_W  = 16;
  localparam int ONES_W    = 22;
  localparam int RCOUNT_W  = 16;
  localparam int POP_W     = 7;
  localparam int OUT_W     = 248;

  localparam logic [SCOUNT_W-1:0] SCOUNT_MAX = '1;
  localparam logic [ONES_W-1:0]   ONES_MAX   = '1;
  localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = '1;
  localparam logic [SAMPLE_W-1:0] ALL_ONES   = '1;

  // Window statistics kept between transactions
  typedef struct packed {
    logic [SCOUNT_W-1:0] success_count;
    logic [ONES_W-1:0]   ones_total;
    logic [SAMPLE_W-1:0] or_accum;
    logic [SAMPLE_W-1:0] and_accum;
    logic [SAMPLE_W-1:0] prev_sample;
    logic                have_prev;
    logic [RCOUNT_W-1:0] repeat_count;
    logic [SAMPLE_W-1:0] first_nonzero;
  } stats_t;

  localparam stats_t STATS_RESET = '{
    success_count: '0,
    ones_total:    '0,
    or_accum:      '0,
    and_accum:     ALL_ONES,
    prev_sample:   '0,
    have_prev:     1'b0,
    repeat_count:  '0,
    first_nonzero: '0
  };

endpackage

`default_nettype wire

### hdl/rshs_popcount.sv
`timescale 1ns / 1ps
`default_nettype none

module rshs_popcount
  import rshs_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [POP_W-1:0]    ones
);

  // Balanced adder tree, one level per stage of the loop below
  logic [1:0] lvl1 [32];
  logic [2:0] lvl2 [16];
  logic [3:0] lvl3 [8];
  logic [4:0] lvl4 [4];
  logic [5:0] lvl5 [2];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      lvl1[i] = {1'b0, sample[2*i]} + {1'b0, sample[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
    end
    ones = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
  end

endmodule

`default_nettype wire

### hdl/rshs_update.sv
`timescale 1ns / 1ps
`default_nettype none

module rshs_update
  import rshs_pkg::*;
(
  input  wire stats_t              cur,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                sample_ok,
  input  wire logic                clear_window,
  output stats_t                   nxt
);

  stats_t            base;
  logic [POP_W-1:0]  ones;
  logic [ONES_W:0]   ones_sum;
  logic              is_repeat;

  rshs_popcount u_pop (
    .sample (sample),
    .ones   (ones)
  );

  always_comb begin
    base      = clear_window ? STATS_RESET : cur;
    ones_sum  = {1'b0, base.ones_total} + {{(ONES_W+1-POP_W){1'b0}}, ones};
    is_repeat = base.have_prev && (sample == base.prev_sample);
    nxt       = base;
    if (sample_ok) begin
      if (base.success_count != SCOUNT_MAX) begin
        nxt.success_count = base.success_count + 1'b1;
      end
      nxt.ones_total = ones_sum[ONES_W] ? ONES_MAX : ones_sum[ONES_W-1:0];
      nxt.or_accum   = base.or_accum | sample;
      nxt.and_accum  = base.and_accum & sample;
      if (is_repeat && base.repeat_count != RCOUNT_MAX) begin
        nxt.repeat_count = base.repeat_count + 1'b1;
      end
      nxt.prev_sample = sample;
      nxt.have_prev   = 1'b1;
      if (base.first_nonzero == '0) begin
        nxt.first_nonzero = sample;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/random_sample_health_stats.sv
`timescale 1ns / 1ps
`default_nettype none

// Health statistics for a 64-bit random generator.
// Input channel (in_*): one transaction per generator attempt. in_tdata holds
// the sample; in_tuser flags whether the generator reported success and
// whether the statistics window restarts before this sample is taken in.
// Output channel (out_*): exactly one transaction per input transaction, a
// snapshot of all statistics after that attempt has been applied.
// A result passes from the input register into the result register and is
// offered from there; a stall can hold it in either register.
// Throughput: one transaction per cycle while the receiver does not stall;
// the popcount tree and accumulator update lie between the two registers.
// When the receiver stalls, the result register holds its snapshot and the
// input register keeps one more transaction; in_tready drops only when both
// are full and out_tready is low.
// Reset (rst_n low, synchronous) empties both registers and restores the
// statistics: counters zero, OR and first-nonzero zero, AND all ones, and no
// previous sample.

module random_sample_health_stats
  import rshs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [SAMPLE_W-1:0] in_tdata,   // [63:0] sample
  input  wire logic [1:0]          in_tuser,   // [0] sample_ok, [1] clear_window
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [15:0] success_count, [37:16] ones_total, [101:38] or_accum,
  // [165:102] and_accum, [181:166] repeat_count, [245:182] first_nonzero,
  // [247:246] zero
  output logic      [OUT_W-1:0]    out_tdata
);

  // Input register
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                ok_r;
  logic                clr_r;

  // Statistics and result register
  stats_t              stats_r;
  stats_t              stats_nxt;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_W-1:0]    out_data_nxt;

  logic                advance;

  // Move the held transaction into the result register when that slot is
  // free or being emptied this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  rshs_update u_update (
    .cur          (stats_r),
    .sample       (sample_r),
    .sample_ok    (ok_r),
    .clear_window (clr_r),
    .nxt          (stats_nxt)
  );

  assign out_data_nxt = {2'b00,
                         stats_nxt.first_nonzero,
                         stats_nxt.repeat_count,
                         stats_nxt.and_accum,
                         stats_nxt.or_accum,
                         stats_nxt.ones_total,
                         stats_nxt.success_count};

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_tdata;
      ok_r     <= in_tuser[0];
      clr_r    <= in_tuser[1];
    end
  end

  // Commit the statistics only as the snapshot leaves for the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r     <= STATS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        stats_r <= stats_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
